// ===== src/radial_deadzone_stick_scaler_defines.svh =====
// Assertion macros shared by the stick scaler checker.
`ifndef RADIAL_DEADZONE_STICK_SCALER_DEFINES_SVH
`define RADIAL_DEADZONE_STICK_SCALER_DEFINES_SVH
// Assert an implication on the rising clock edge, disabled in reset.
`define RDS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");
// Assert an implication whose consequent is checked in the following cycle.
`define RDS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");
`endif

// ===== src/rdss_pkg.sv =====
// Package with payload types, sizes and the shared sequencing constants.
package rdss_pkg;
    localparam int unsigned AxisMax  = 32767;
    localparam int unsigned SqrtBits = 24;   // root of a 48-bit radicand
    // Input, squares, root load, root stages, three scaling stages,
    // 17 divider stages and the byte register.
    localparam int unsigned Latency  = SqrtBits + 24;
    localparam logic [7:0]  Centre   = 8'h80;
    localparam logic        RegDeadZone  = 1'b0;
    localparam logic        RegDpadMerge = 1'b1;

    typedef struct packed {
        logic signed [15:0] left_x;
        logic signed [15:0] left_y;
        logic signed [15:0] right_x;
        logic signed [15:0] right_y;
        logic               dpad_left;
        logic               dpad_right;
        logic               dpad_up;
        logic               dpad_down;
    } t_in;

    typedef struct packed {
        logic [7:0] pad_lx;
        logic [7:0] pad_ly;
        logic [7:0] pad_rx;
        logic [7:0] pad_ry;
        logic       left_active;
    } t_out;
endpackage

// ===== src/radial_deadzone_stick_scaler.sv =====
// Top level: two stick lanes, d-pad merge and the result strobe.
// The strobe marks the results of the accepted item, carried through 2 input stages,
// root load, 24 root stages, 3 scaling stages, 17 divider stages and the byte register.
// Throughput: one transaction per cycle; busy is never raised.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Reset (synchronous, active low) clears the config registers and the valid pipe.
module radial_deadzone_stick_scaler (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  rdss_pkg::t_in        i_item,
    output logic                 o_strobe,
    output rdss_pkg::t_out       o_result,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [0:0]           i_cfg_index,
    input  logic [14:0]          i_cfg_data
);
    import rdss_pkg::*;

    logic [14:0] r_dead_zone;
    logic        r_dpad_merge;
    logic [Latency-1:0] r_vld;
    logic [3:0]  r_dpad [0:Latency-1];

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    // Take register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dead_zone  <= '0;
            r_dpad_merge <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                RegDeadZone:  r_dead_zone  <= i_cfg_data;
                RegDpadMerge: r_dpad_merge <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Advance the valid pipe alongside the lanes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else          r_vld <= {r_vld[Latency-2:0], start};
    end

    // Carry the d-pad bits to the merge stage, level with the lane outputs.
    always_ff @(posedge i_clk) begin
        r_dpad[0] <= {i_item.dpad_left, i_item.dpad_right, i_item.dpad_up, i_item.dpad_down};
        for (int k = 1; k < Latency; k++) r_dpad[k] <= r_dpad[k-1];
    end

    logic [7:0] lx, ly, rx, ry;
    logic       lact, ract;
    rdss_lane u_left (.i_clk, .i_x(i_item.left_x), .i_y(i_item.left_y),
        .i_dz(r_dead_zone), .o_bx(lx), .o_by(ly), .o_active(lact));
    rdss_lane u_right (.i_clk, .i_x(i_item.right_x), .i_y(i_item.right_y),
        .i_dz(r_dead_zone), .o_bx(rx), .o_by(ry), .o_active(ract));

    // Merge: when enabled, fold the d-pad over the left bytes; right or down wins.
    logic [3:0] dp;
    assign dp = r_dpad[Latency-1];
    always_comb begin
        o_result.pad_lx = lx;
        o_result.pad_ly = ly;
        if (r_dpad_merge) begin
            if (dp[3]) o_result.pad_lx = 8'h00;
            if (dp[2]) o_result.pad_lx = 8'hFF;
            if (dp[1]) o_result.pad_ly = 8'h00;
            if (dp[0]) o_result.pad_ly = 8'hFF;
        end
        o_result.pad_rx      = rx;
        o_result.pad_ry      = ry;
        o_result.left_active = lact;
    end
    assign o_strobe = r_vld[Latency-1];
    logic unused;
    assign unused = ract;
endmodule

// ===== src/rdss_div.sv =====
// Pipelined restoring divider: one quotient bit per stage.
module rdss_div (
    input  logic        i_clk,
    input  logic [57:0] i_num,
    input  logic [40:0] i_den,
    output logic [15:0] o_quo
);
    // Quotient is clamped here to 16 bits; track saturation with a flag.
    logic [57:0] r_rem [0:16];
    logic [40:0] r_den [0:16];
    logic [15:0] r_quo [0:16];
    logic        r_sat [0:16];
    logic [73:0] n_trial [0:15];

    always_comb begin
        for (int k = 0; k < 16; k++) begin
            n_trial[k] = {16'd0, r_rem[k]} - ({33'd0, r_den[k]} << (15 - k));
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0] <= i_num;
        r_den[0] <= i_den;
        r_quo[0] <= '0;
        // Quotient >= 2^16 means saturate.
        r_sat[0] <= ({16'd0, i_num} >= ({33'd0, i_den} << 16));
        for (int k = 0; k < 16; k++) begin
            r_den[k+1] <= r_den[k];
            r_sat[k+1] <= r_sat[k];
            if (!n_trial[k][73]) begin
                r_rem[k+1] <= n_trial[k][57:0];
                r_quo[k+1] <= r_quo[k] | (16'd1 << (15 - k));
            end else begin
                r_rem[k+1] <= r_rem[k];
                r_quo[k+1] <= r_quo[k];
            end
        end
    end

    assign o_quo = r_sat[16] ? 16'hFFFF : r_quo[16];
endmodule

// ===== src/rdss_lane.sv =====
// One stick lane: dead-zone test, pipelined root, scale and byte reduction.
module rdss_lane (
    input  logic               i_clk,
    input  logic signed [15:0] i_x,
    input  logic signed [15:0] i_y,
    input  logic [14:0]        i_dz,
    output logic [7:0]         o_bx,
    output logic [7:0]         o_by,
    output logic               o_active
);
    import rdss_pkg::*;
    localparam int unsigned N = SqrtBits;

    // stage A: magnitudes, then a stage of squares
    logic [16:0] r_ax, r_ay;
    logic        r_nx, r_ny;
    logic [14:0] r_dz;
    always_ff @(posedge i_clk) begin
        r_nx <= i_x[15];
        r_ny <= i_y[15];
        r_ax <= i_x[15] ? 17'(-{i_x[15], i_x}) : {1'b0, i_x};
        r_ay <= i_y[15] ? 17'(-{i_y[15], i_y}) : {1'b0, i_y};
        r_dz <= i_dz;
    end
    logic [31:0] r_sx, r_sy, r_dd;
    logic [16:0] r_ax2, r_ay2;
    logic        r_nx2, r_ny2;
    logic [14:0] r_dz2;
    always_ff @(posedge i_clk) begin
        r_sx  <= 32'(r_ax * r_ax);
        r_sy  <= 32'(r_ay * r_ay);
        r_dd  <= 32'(r_dz * r_dz);
        r_ax2 <= r_ax; r_ay2 <= r_ay; r_nx2 <= r_nx; r_ny2 <= r_ny; r_dz2 <= r_dz;
    end

    // square root pipeline, one result bit per stage
    logic [47:0] r_v    [0:N];
    logic [24:0] r_root [0:N];
    logic        r_act  [0:N];
    logic [16:0] r_qx   [0:N];
    logic [16:0] r_qy   [0:N];
    logic        r_mx   [0:N];
    logic        r_my   [0:N];
    logic [14:0] r_qd   [0:N];
    logic [32:0] n_s;
    assign n_s = {1'b0, r_sx} + {1'b0, r_sy};
    always_ff @(posedge i_clk) begin
        r_v[0]    <= {n_s[31:0], 16'd0};
        r_root[0] <= '0;
        r_act[0]  <= (n_s > {1'b0, r_dd});
        r_qx[0] <= r_ax2; r_qy[0] <= r_ay2; r_mx[0] <= r_nx2; r_my[0] <= r_ny2;
        r_qd[0] <= r_dz2;
        for (int k = 0; k < N; k++) begin
            // bit-by-bit root: trial = (root<<2 | 1) << (2*(N-1-k)) with root so far
            logic [49:0] tr;
            logic [49:0] t_rem;
            tr    = ({23'd0, r_root[k], 2'b01} << (2 * (N - 1 - k)));
            t_rem = {2'd0, r_v[k]};
            if (t_rem >= tr) begin
                r_v[k+1]    <= 48'(t_rem - tr);
                r_root[k+1] <= {r_root[k][23:0], 1'b1};
            end else begin
                r_v[k+1]    <= r_v[k];
                r_root[k+1] <= {r_root[k][23:0], 1'b0};
            end
            r_act[k+1] <= r_act[k];
            r_qx[k+1] <= r_qx[k]; r_qy[k+1] <= r_qy[k];
            r_mx[k+1] <= r_mx[k]; r_my[k+1] <= r_my[k]; r_qd[k+1] <= r_qd[k];
        end
    end

    // diff and denominator
    logic [24:0] m;
    assign m = r_root[N];
    logic [22:0] r_diff;
    logic [39:0] r_den;
    logic [16:0] r_px, r_py;
    logic        r_pnx, r_pny, r_pact;
    always_ff @(posedge i_clk) begin
        logic [24:0] c, d;
        logic [14:0] rg;
        c = (m > 25'(AxisMax << 8)) ? 25'(AxisMax << 8) : m;
        d = {2'd0, r_qd[N], 8'd0};
        rg = (r_qd[N] < 15'(AxisMax)) ? 15'(15'(AxisMax) - r_qd[N]) : 15'd1;
        r_diff <= (c > d) ? 23'(c - d) : 23'd0;
        r_den  <= (m == 0) ? 40'd1 : 40'(rg * m);
        r_px <= r_qx[N]; r_py <= r_qy[N];
        r_pnx <= r_mx[N]; r_pny <= r_my[N]; r_pact <= r_act[N];
    end
    // numerators a*diff*32767, twice plus den
    logic [39:0] r_ad_x, r_ad_y, r_den2;
    logic        r_nx3, r_ny3, r_act3;
    always_ff @(posedge i_clk) begin
        r_ad_x <= 40'(r_px * r_diff);
        r_ad_y <= 40'(r_py * r_diff);
        r_den2 <= r_den;
        r_nx3 <= r_pnx; r_ny3 <= r_pny; r_act3 <= r_pact;
    end
    logic [56:0] r_nm_x, r_nm_y;
    logic [39:0] r_den3;
    logic        r_nx4, r_ny4, r_act4;
    always_ff @(posedge i_clk) begin
        r_nm_x <= 57'(r_ad_x * 15'(AxisMax));
        r_nm_y <= 57'(r_ad_y * 15'(AxisMax));
        r_den3 <= r_den2;
        r_nx4 <= r_nx3; r_ny4 <= r_ny3; r_act4 <= r_act3;
    end

    // Round half up on the magnitude: (2n + den) / (2 den), one divider per axis.
    logic [15:0] qx, qy;
    logic [57:0] nx_full, ny_full;
    logic [40:0] den_x2;
    assign nx_full = {r_nm_x, 1'b0} + {18'd0, r_den3};
    assign ny_full = {r_nm_y, 1'b0} + {18'd0, r_den3};
    assign den_x2  = {r_den3, 1'b0};

    rdss_div u_div_x (.i_clk, .i_num(nx_full), .i_den(den_x2), .o_quo(qx));
    rdss_div u_div_y (.i_clk, .i_num(ny_full), .i_den(den_x2), .o_quo(qy));

    // Carry signs and the zone flag beside the divider stages.
    logic [16:0] r_dn_x, r_dn_y, r_da;
    always_ff @(posedge i_clk) begin
        r_dn_x <= {r_dn_x[15:0], r_nx4};
        r_dn_y <= {r_dn_y[15:0], r_ny4};
        r_da   <= {r_da[15:0], r_act4};
    end

    function automatic logic [7:0] to_byte(input logic [15:0] q, input logic neg);
        logic [16:0] qc, u;
        if (neg) begin
            qc = (q > 16'd32768) ? 17'd32768 : {1'b0, q};
            u  = 17'd32768 - qc;
        end else begin
            qc = (q > 16'd32767) ? 17'd32767 : {1'b0, q};
            u  = 17'd32768 + qc;
        end
        return u[15:8];
    endfunction

    always_ff @(posedge i_clk) begin
        o_active <= r_da[16];
        o_bx <= r_da[16] ? to_byte(qx, r_dn_x[16]) : Centre;
        o_by <= r_da[16] ? to_byte(qy, r_dn_y[16]) : Centre;
    end
    logic unused;
    assign unused = n_s[32];
endmodule

// ===== src/rdss_checker.sv =====
// Port checker for the stick scaler, bound to the top level.
`include "radial_deadzone_stick_scaler_defines.svh"
module rdss_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           start,
    input logic           busy,
    input logic           o_strobe,
    input logic           o_cfg_ready,
    input rdss_pkg::t_out o_result
);
    import rdss_pkg::*;
    `RDS_ASSERT_IMP(a_never_busy, i_clk, i_rst_n, 1'b1, !busy)
    `RDS_ASSERT_IMP(a_cfg_ready, i_clk, i_rst_n, 1'b1, o_cfg_ready)
    `RDS_ASSERT_IMP(a_result_known, i_clk, i_rst_n, o_strobe, !$isunknown(o_result))
    `RDS_ASSERT_IMP(a_strobe_has_start, i_clk, i_rst_n, o_strobe, $past(start, Latency))
    `RDS_ASSERT_NEXT(a_start_gives_strobe, i_clk, i_rst_n, start && !busy, ##(Latency - 1) o_strobe)
endmodule

bind radial_deadzone_stick_scaler rdss_checker u_chk (.i_clk, .i_rst_n, .start, .busy,
    .o_strobe, .o_cfg_ready, .o_result);
